// File: hdl/yqa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yqa_pkg
// Shared types and constants for the YUV 4:2:0 quad to ARGB converter.
// ----------------------------------------------------------------------------
package yqa_pkg;

  localparam int unsigned NumLanes  = 4;
  localparam int unsigned CoefW     = 10;
  localparam int unsigned SampleW   = 8;
  localparam int unsigned DiffW     = 9;   // signed sample minus offset
  localparam int unsigned ProdW     = 20;  // signed product / chroma term
  localparam int unsigned SumW      = 21;  // signed per-channel sum
  localparam int unsigned PixelW    = 32;

  localparam logic [DiffW-1:0] ChromaZero = 9'd128;

  typedef enum logic [2:0] {
    REG_LUMA_GAIN   = 3'd0,
    REG_LUMA_OFFSET = 3'd1,
    REG_CR_TO_RED   = 3'd2,
    REG_CR_TO_GREEN = 3'd3,
    REG_CB_TO_GREEN = 3'd4,
    REG_CB_TO_BLUE  = 3'd5,
    REG_ALPHA_VALUE = 3'd6,
    REG_UNUSED      = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [CoefW-1:0]   luma_gain;
    logic [SampleW-1:0] luma_offset;
    logic [CoefW-1:0]   cr_to_red;
    logic [CoefW-1:0]   cr_to_green;
    logic [CoefW-1:0]   cb_to_green;
    logic [CoefW-1:0]   cb_to_blue;
    logic [SampleW-1:0] alpha_value;
  } cfg_t;

endpackage

// File: hdl/yqa_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yqa_cfg_regs
// APB register file holding the conversion matrix, black level and alpha.
// ----------------------------------------------------------------------------
module yqa_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output yqa_pkg::cfg_t     cfg_o
);
  import yqa_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[4:2]);
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_LUMA_GAIN:   cfg_d.luma_gain   = pwdata[CoefW-1:0];
        REG_LUMA_OFFSET: cfg_d.luma_offset = pwdata[SampleW-1:0];
        REG_CR_TO_RED:   cfg_d.cr_to_red   = pwdata[CoefW-1:0];
        REG_CR_TO_GREEN: cfg_d.cr_to_green = pwdata[CoefW-1:0];
        REG_CB_TO_GREEN: cfg_d.cb_to_green = pwdata[CoefW-1:0];
        REG_CB_TO_BLUE:  cfg_d.cb_to_blue  = pwdata[CoefW-1:0];
        REG_ALPHA_VALUE: cfg_d.alpha_value = pwdata[SampleW-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LUMA_GAIN:   prdata = {22'd0, cfg_q.luma_gain};
      REG_LUMA_OFFSET: prdata = {24'd0, cfg_q.luma_offset};
      REG_CR_TO_RED:   prdata = {22'd0, cfg_q.cr_to_red};
      REG_CR_TO_GREEN: prdata = {22'd0, cfg_q.cr_to_green};
      REG_CB_TO_GREEN: prdata = {22'd0, cfg_q.cb_to_green};
      REG_CB_TO_BLUE:  prdata = {22'd0, cfg_q.cb_to_blue};
      REG_ALPHA_VALUE: prdata = {24'd0, cfg_q.alpha_value};
      default:         prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.luma_gain   <= 10'd298;
      cfg_q.luma_offset <= 8'd16;
      cfg_q.cr_to_red   <= 10'd409;
      cfg_q.cr_to_green <= 10'd208;
      cfg_q.cb_to_green <= 10'd100;
      cfg_q.cb_to_blue  <= 10'd517;
      cfg_q.alpha_value <= 8'd255;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hdl/yqa_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yqa_lane
// One pixel lane: luma plus red/blue, minus green, shifts by 8, clamps, packs.
// ----------------------------------------------------------------------------
module yqa_lane (
  input  logic signed [19:0] yt_i,
  input  logic signed [19:0] red_term_i,
  input  logic signed [19:0] green_term_i,
  input  logic signed [19:0] blue_term_i,
  input  logic [7:0]         alpha_i,
  output logic [31:0]        pixel_o
);
  import yqa_pkg::*;

  function automatic logic [7:0] clamp_q8(input logic signed [SumW-1:0] s);
    logic [7:0] res;
    if (s[SumW-1]) begin
      res = 8'd0;
    end else if (|s[SumW-2:16]) begin
      res = 8'hff;
    end else begin
      res = s[15:8];
    end
    return res;
  endfunction

  logic signed [SumW-1:0] yt_x, sum_r, sum_g, sum_b;

  assign yt_x  = {yt_i[ProdW-1], yt_i};
  assign sum_r = yt_x + {red_term_i[ProdW-1], red_term_i};
  assign sum_g = yt_x - {green_term_i[ProdW-1], green_term_i};
  assign sum_b = yt_x + {blue_term_i[ProdW-1], blue_term_i};

  assign pixel_o = {alpha_i, clamp_q8(sum_r), clamp_q8(sum_g), clamp_q8(sum_b)};

endmodule

// File: hdl/yuv420_quad_to_argb_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yuv420_quad_to_argb_unit
// BT.601 video-range YCbCr 2x2 quad to four packed ARGB pixels.
// Pipeline: 4 register stages (offset subtract, multiply, green term add,
//   sum/clamp into output register).
// Throughput: one quad per cycle; the whole pipe holds only on output backpressure.
// Reset: pipeline valid bits clear; registers return to BT.601 defaults, alpha 0xff.
// ----------------------------------------------------------------------------
module yuv420_quad_to_argb_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  // APB configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right,
  // chroma_blue, chroma_red (8 bits each, from bit 0)
  input  logic [47:0]  s_axis_tdata,
  // output stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pixel_top_left, pixel_top_right, pixel_bottom_left, pixel_bottom_right
  // (32 bits each, from bit 0)
  output logic [127:0] m_axis_tdata
);
  import yqa_pkg::*;

  cfg_t cfg;
  logic en;

  yqa_cfg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  logic v1_q, v2_q, v3_q, v4_q;

  // stage 1: centered samples
  logic signed [DiffW-1:0] ydiff_q1 [NumLanes];
  logic signed [DiffW-1:0] cb_q1, cr_q1;
  // stage 2: products
  logic signed [ProdW-1:0] yt_q2 [NumLanes];
  logic signed [ProdW-1:0] rt_q2, gcr_q2, gcb_q2, bt_q2;
  // stage 3: chroma terms
  logic signed [ProdW-1:0] yt_q3 [NumLanes];
  logic signed [ProdW-1:0] rt_q3, gt_q3, bt_q3;
  // stage 4: pixels
  logic [PixelW-1:0] pix_d4 [NumLanes];
  logic [PixelW-1:0] pix_q4 [NumLanes];

  assign en            = !v4_q || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < NumLanes; i++) begin
        ydiff_q1[i] <= $signed({1'b0, s_axis_tdata[i*SampleW +: SampleW]})
                     - $signed({1'b0, cfg.luma_offset});
      end
      cb_q1 <= $signed({1'b0, s_axis_tdata[4*SampleW +: SampleW]}) - $signed(ChromaZero);
      cr_q1 <= $signed({1'b0, s_axis_tdata[5*SampleW +: SampleW]}) - $signed(ChromaZero);

      for (int i = 0; i < NumLanes; i++) begin
        yt_q2[i] <= ProdW'($signed({1'b0, cfg.luma_gain})) * ProdW'(ydiff_q1[i]);
      end
      rt_q2  <= ProdW'($signed({1'b0, cfg.cr_to_red})) * ProdW'(cr_q1);
      gcr_q2 <= ProdW'($signed({1'b0, cfg.cr_to_green})) * ProdW'(cr_q1);
      gcb_q2 <= ProdW'($signed({1'b0, cfg.cb_to_green})) * ProdW'(cb_q1);
      bt_q2  <= ProdW'($signed({1'b0, cfg.cb_to_blue})) * ProdW'(cb_q1);

      yt_q3 <= yt_q2;
      rt_q3 <= rt_q2;
      gt_q3 <= gcr_q2 + gcb_q2;
      bt_q3 <= bt_q2;

      pix_q4 <= pix_d4;
    end
  end

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    yqa_lane u_lane (
      .yt_i         (yt_q3[g]),
      .red_term_i   (rt_q3),
      .green_term_i (gt_q3),
      .blue_term_i  (bt_q3),
      .alpha_i      (cfg.alpha_value),
      .pixel_o      (pix_d4[g])
    );
    assign m_axis_tdata[g*PixelW +: PixelW] = pix_q4[g];
  end

endmodule

// File: hdl/yqa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yqa_checker
// Port-level checks for the quad converter, bound to the top level.
// ----------------------------------------------------------------------------
module yqa_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [127:0] m_axis_tdata
);
  logic       s_xact;
  logic       m_xact;
  logic [2:0] inflight_q, inflight_d;

  assign s_xact = s_axis_tvalid && s_axis_tready;
  assign m_xact = m_axis_tvalid && m_axis_tready;

  always_comb begin
    inflight_d = inflight_q;
    if (s_xact && !m_xact) begin
      inflight_d = inflight_q + 3'd1;
    end else if (!s_xact && m_xact) begin
      inflight_d = inflight_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= 3'd0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // stalled output transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

  // input only blocks on output backpressure
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output backpressure");

  // unobstructed transaction reaches the output once through the pipeline
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(s_xact, 4) && $past(rst_ni, 4) && $past(rst_ni, 3) && $past(rst_ni, 2)
    && $past(rst_ni, 1) && $past(m_axis_tready, 1) && $past(m_axis_tready, 2)
    && $past(m_axis_tready, 3) |-> m_axis_tvalid)
    else $error("result missing after pipeline latency");

  // no result from an empty pipe
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> inflight_q != 3'd0)
    else $error("result without input transaction");

  // never more transactions in flight than pipeline stages
  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 3'd4)
    else $error("more transactions in flight than pipeline stages");

endmodule

bind yuv420_quad_to_argb_unit yqa_checker u_yqa_checker (.*);

// File: tb/yqa_argb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yqa_argb_checker
// Watches the APB port and both streams of the quad converter. It tracks the
// register file from observed writes and checks APB reads against it. For
// every accepted quad it computes the four expected ARGB pixels. It compares
// each output transaction, pixel by pixel, with the oldest pending
// expectation.
// ----------------------------------------------------------------------------
module yqa_argb_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic [31:0]  prdata,
  input  logic         pready,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  // luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right,
  // chroma_blue, chroma_red (8 bits each, from bit 0)
  input  logic [47:0]  s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pixel_top_left, pixel_top_right, pixel_bottom_left, pixel_bottom_right
  // (32 bits each, from bit 0)
  input  logic [127:0] m_axis_tdata,
  output int unsigned  pending_o,
  output int unsigned  errors_o
);
  import yqa_pkg::*;

  cfg_t             cfg;
  logic [127:0]     argb_expected_q[$];
  string            pixel_name[NumLanes] = '{"pixel_top_left", "pixel_top_right",
                                             "pixel_bottom_left", "pixel_bottom_right"};

  function automatic logic [7:0] sat8(input int sum);
    if (sum < 0) return 8'h00;
    if ((sum >>> 8) > 255) return 8'hff;
    return sum[15:8];
  endfunction

  function automatic logic [127:0] quad_to_argb(input logic [47:0] quad, input cfg_t c);
    int           cb;
    int           cr;
    int           red_t;
    int           green_t;
    int           blue_t;
    int           yt;
    logic [127:0] px;
    cb      = int'(quad[39:32]) - int'(ChromaZero);
    cr      = int'(quad[47:40]) - int'(ChromaZero);
    red_t   = int'(c.cr_to_red) * cr;
    green_t = int'(c.cr_to_green) * cr + int'(c.cb_to_green) * cb;
    blue_t  = int'(c.cb_to_blue) * cb;
    px      = '0;
    for (int lane = 0; lane < NumLanes; lane++) begin
      yt = int'(c.luma_gain) * (int'(quad[lane*SampleW +: SampleW]) - int'(c.luma_offset));
      px[lane*PixelW +: PixelW] = {c.alpha_value, sat8(yt + red_t), sat8(yt - green_t),
                                   sat8(yt + blue_t)};
    end
    return px;
  endfunction

  function automatic logic [31:0] reg_value(input reg_idx_e idx);
    case (idx)
      REG_LUMA_GAIN:   return 32'(cfg.luma_gain);
      REG_LUMA_OFFSET: return 32'(cfg.luma_offset);
      REG_CR_TO_RED:   return 32'(cfg.cr_to_red);
      REG_CR_TO_GREEN: return 32'(cfg.cr_to_green);
      REG_CB_TO_GREEN: return 32'(cfg.cb_to_green);
      REG_CB_TO_BLUE:  return 32'(cfg.cb_to_blue);
      REG_ALPHA_VALUE: return 32'(cfg.alpha_value);
      default:         return '0;
    endcase
  endfunction

  function automatic void report(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    errors_o++;
    $error("%s: expected %08h, actual %08h", field, want, got);
  endfunction

  initial begin
    errors_o  = 0;
    pending_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    logic [127:0] want;
    reg_idx_e     idx;
    if (!rst_ni) begin
      cfg.luma_gain   = 10'd298;
      cfg.luma_offset = 8'd16;
      cfg.cr_to_red   = 10'd409;
      cfg.cr_to_green = 10'd208;
      cfg.cb_to_green = 10'd100;
      cfg.cb_to_blue  = 10'd517;
      cfg.alpha_value = 8'd255;
      argb_expected_q.delete();
    end else begin
      idx = reg_idx_e'(paddr[4:2]);
      if (psel && penable && pready && pwrite) begin
        case (idx)
          REG_LUMA_GAIN:   cfg.luma_gain   = pwdata[CoefW-1:0];
          REG_LUMA_OFFSET: cfg.luma_offset = pwdata[SampleW-1:0];
          REG_CR_TO_RED:   cfg.cr_to_red   = pwdata[CoefW-1:0];
          REG_CR_TO_GREEN: cfg.cr_to_green = pwdata[CoefW-1:0];
          REG_CB_TO_GREEN: cfg.cb_to_green = pwdata[CoefW-1:0];
          REG_CB_TO_BLUE:  cfg.cb_to_blue  = pwdata[CoefW-1:0];
          REG_ALPHA_VALUE: cfg.alpha_value = pwdata[SampleW-1:0];
          default: ;
        endcase
      end
      if (psel && penable && pready && !pwrite && idx != REG_UNUSED) begin
        if (prdata !== reg_value(idx)) report(idx.name(), reg_value(idx), prdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (argb_expected_q.size() == 0) begin
          report("m_axis_tdata (unexpected transaction)", '0, m_axis_tdata[31:0]);
        end else begin
          want = argb_expected_q.pop_front();
          for (int lane = 0; lane < NumLanes; lane++) begin
            if (m_axis_tdata[lane*PixelW +: PixelW] !== want[lane*PixelW +: PixelW]) begin
              report(pixel_name[lane], want[lane*PixelW +: PixelW],
                     m_axis_tdata[lane*PixelW +: PixelW]);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) argb_expected_q.push_back(quad_to_argb(s_axis_tdata, cfg));
    end
    pending_o = argb_expected_q.size();
  end

endmodule

// File: tb/tb_yuv420_quad_to_argb_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_yuv420_quad_to_argb_unit
// Drives the quad converter through several register settings (reset values,
// all maximum, all zero, random, BT.601 restored). Each setting gets directed
// or random quads with random gaps and backpressure, including one long
// output stall. A side checker predicts and compares every pixel.
// ----------------------------------------------------------------------------
module tb_yuv420_quad_to_argb_unit;
  import yqa_pkg::*;

  localparam int unsigned CyclesMax    = 1000000;
  localparam int unsigned Phases       = 8;
  localparam int unsigned QuadsPerPhase = 225;
  localparam int unsigned LongHoldAt   = 560;
  localparam int unsigned LongHoldLen  = 240;
  localparam int unsigned DrainCycles  = 12;

  logic         clk_i;
  logic         rst_ni;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [4:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right,
  // chroma_blue, chroma_red (8 bits each, from bit 0)
  logic [47:0]  s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // pixel_top_left, pixel_top_right, pixel_bottom_left, pixel_bottom_right
  // (32 bits each, from bit 0)
  logic [127:0] m_axis_tdata;

  int unsigned  pending;
  int unsigned  errors;
  int unsigned  pixels_taken;
  logic [7:0]   cur_offset;
  bit           tx_burst;
  bit           rx_burst;

  int unsigned  reg_width[7] = '{CoefW, SampleW, CoefW, CoefW, CoefW, CoefW, SampleW};

  yuv420_quad_to_argb_unit i_dut (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  yqa_argb_checker i_checker (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .pending_o (pending),
    .errors_o  (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (CyclesMax) @(posedge clk_i);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // mostly short, a few long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_sample();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hff;
      2:       return 8'($urandom_range(120, 136));
      3:       return cur_offset + 8'($urandom_range(0, 4)) - 8'd2;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [47:0] random_quad();
    logic [47:0] q;
    if ($urandom_range(0, 9) < 6) return {16'($urandom), $urandom};
    for (int k = 0; k < 6; k++) q[k*8 +: 8] = pick_sample();
    return q;
  endfunction

  function automatic logic [31:0] with_junk(input int unsigned val, input int unsigned w);
    return ($urandom << w) | val;
  endfunction

  task automatic apb_access(input reg_idx_e idx, input logic wr, input logic [31:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic read_all_regs();
    for (int i = 0; i <= REG_UNUSED; i++) apb_access(reg_idx_e'(i), 1'b0, '0);
  endtask

  task automatic send_quad(input logic [47:0] quad);
    int unsigned gap;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= quad;
    do @(posedge clk_i); while (!s_axis_tready);
    if ($urandom_range(0, 59) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= {16'($urandom), $urandom};
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic program_phase(input int unsigned ph);
    int unsigned val[7];
    case (ph)
      1: val = '{1023, 255, 1023, 1023, 1023, 1023, 255};
      2: val = '{0, 0, 0, 0, 0, 0, 0};
      Phases - 1: val = '{298, 16, 409, 208, 100, 517, 255};
      default: begin
        for (int i = 0; i < 7; i++) val[i] = $urandom_range(0, (1 << reg_width[i]) - 1);
      end
    endcase
    for (int i = 0; i < 7; i++) apb_access(reg_idx_e'(i), 1'b1, with_junk(val[i], reg_width[i]));
    apb_access(REG_UNUSED, 1'b1, $urandom);
    cur_offset = 8'(val[REG_LUMA_OFFSET]);
    read_all_regs();
  endtask

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) pixels_taken++;
  end

  // output side: random stalls, bursts, and one long hold while input keeps coming
  initial begin
    int unsigned stall;
    bit          long_done;
    m_axis_tready = 1'b0;
    stall         = 0;
    long_done     = 1'b0;
    rx_burst      = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else if (!long_done && pixels_taken >= LongHoldAt) begin
        long_done      = 1'b1;
        stall          = LongHoldLen - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        stall          = rx_burst ? 0 : pick_gap();
      end
      if ($urandom_range(0, 99) == 0) rx_burst = !rx_burst;
    end
  end

  initial begin
    logic [47:0] directed[$];
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    pixels_taken  = 0;
    cur_offset    = 8'd16;
    tx_burst      = 1'b0;

    // {Cr, Cb, Y bottom right, Y bottom left, Y top right, Y top left}
    directed = '{
      48'h00_00_00_00_00_00,   // everything negative
      48'hff_ff_ff_ff_ff_ff,
      48'h80_80_10_10_10_10,   // black
      48'h80_80_eb_eb_eb_eb,   // white
      48'h80_80_11_10_0f_00,   // around the black level
      48'hff_80_ff_ff_ff_ff,   // red saturates
      48'h80_ff_00_00_00_00,   // blue from zero luma
      48'h00_00_80_80_80_80,   // green saturates
      48'haa_55_ff_aa_55_00,
      48'h55_aa_00_55_aa_ff,
      48'h7f_81_40_c0_20_e0,
      48'h81_7f_e0_20_c0_40,
      48'hff_00_ff_00_ff_00,
      48'h00_ff_00_ff_00_ff
    };

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int unsigned ph = 0; ph < Phases; ph++) begin
      if (ph == 0) begin
        read_all_regs();
        foreach (directed[k]) send_quad(directed[k]);
      end else begin
        wait_drained();
        program_phase(ph);
      end
      repeat (QuadsPerPhase) send_quad(random_quad());
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: yuv420_quad_to_argb_unit.f
hdl/yqa_pkg.sv
hdl/yqa_cfg_regs.sv
hdl/yqa_lane.sv
hdl/yuv420_quad_to_argb_unit.sv
hdl/yqa_checker.sv
tb/yqa_argb_checker.sv
tb/tb_yuv420_quad_to_argb_unit.sv
